[hw/rtl/overwrite_ring_with_filtered_query_macros.svh]
// Assertion macros for the overwrite ring block.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef OVERWRITE_RING_WITH_FILTERED_QUERY_MACROS_SVH
`define OVERWRITE_RING_WITH_FILTERED_QUERY_MACROS_SVH

// same-cycle implication, checked out of reset
`define ORWFQ_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ORWFQ_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

[hw/rtl/orwfq_pkg.sv]
// Shared types and constants for the overwrite ring block.
// No dependencies.
`timescale 1ns / 1ps

package orwfq_pkg;

  // default build sizes
  localparam int unsigned RingDepthDef   = 64;
  localparam int unsigned PayloadBitsDef = 64;

  // fixed field widths
  localparam int unsigned CntW    = 7;
  localparam int unsigned CopyW   = 6;
  localparam int unsigned StampW  = 64;
  localparam int unsigned PidW    = 31;
  localparam int unsigned TidW    = 32;
  localparam int unsigned WordW   = 64;
  localparam int unsigned SatMax  = 127;

  // request codes
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_LATEST = 2'd2
  } req_e;

endpackage

[hw/rtl/overwrite_ring_with_filtered_query.sv]
// Top level of the overwrite-oldest record ring with filtered scan.
// Depends on orwfq_pkg and overwrite_ring_with_filtered_query_macros.svh.
`timescale 1ns / 1ps
`include "overwrite_ring_with_filtered_query_macros.svh"

// Usage
//   Requests: start_i takes a beat while busy_o and cfg_we_i are low.
//   req_type_i 0 stores a record at the head, overwriting the oldest when
//   the ring is full; 1 runs a filtered query; 2 returns the records that
//   carry the newest timestamp. Results leave as one-cycle beats on
//   out_valid_o; the receiver cannot stall, so each beat is shown once.
//   Every request ends in one summary beat with last_item_o set, carrying
//   fill level and the written and dropped counters.
//   Configuration: cfg_we_i writes the ring capacity from cfg_wdata_i and
//   empties the ring; write it only while the block is idle.
//   Sequencing: a write, an undefined request and a query or snapshot of an
//   empty ring go from accept through ST_FIN to their summary beat. A query
//   scans every held record, one per cycle through the single read port of
//   the record memory; a latest snapshot first reads the newest slot. busy_o
//   stays high meanwhile. Record beats follow the scan order, oldest first.
//   Reset: ring empty, counters zero, capacity at the built depth. The
//   record memory is not cleared; only slots written since are read.

module overwrite_ring_with_filtered_query
  import orwfq_pkg::*;
#(
  parameter int unsigned RING_DEPTH   = RingDepthDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               req_type_i,
  input  logic [StampW-1:0]        rec_timestamp_i,
  input  logic [PidW-1:0]          rec_pid_i,
  input  logic signed [TidW-1:0]   rec_tid_i,
  input  logic [WordW-1:0]         rec_payload_i,
  input  logic [StampW-1:0]        from_time_i,
  input  logic [StampW-1:0]        to_time_i,
  input  logic [PidW-1:0]          pid_filter_i,
  input  logic signed [TidW-1:0]   tid_filter_i,
  input  logic [CntW-1:0]          skip_count_i,
  input  logic [CopyW-1:0]         max_copies_i,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CntW-1:0]          cfg_wdata_i,
  // result channel
  output logic                     out_valid_o,
  output logic                     is_record_o,
  output logic                     last_item_o,
  output logic [StampW-1:0]        out_timestamp_o,
  output logic [PidW-1:0]          out_pid_o,
  output logic signed [TidW-1:0]   out_tid_o,
  output logic [WordW-1:0]         out_payload_o,
  output logic [CntW-1:0]          matched_total_o,
  output logic [CopyW-1:0]         copied_total_o,
  output logic [CntW-1:0]          used_count_o,
  output logic [WordW-1:0]         written_total_o,
  output logic [WordW-1:0]         dropped_total_o
);

  localparam int unsigned PtrW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CapW = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    logic [StampW-1:0]       ts;
    logic [PidW-1:0]         pid;
    logic [TidW-1:0]         tid;
    logic [PAYLOAD_BITS-1:0] pl;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWEST,
    ST_GRAB,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [CapW-1:0]   cap_q, cap_d;
  logic [PtrW-1:0]   wp_q, wp_nxt;
  logic [CapW-1:0]   fill_q;
  logic [WordW-1:0]  written_q, dropped_q;

  // scan control
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_nxt, rd_addr, tail, newest;
  logic [CapW:0]     tail_sum;
  logic [CapW-1:0]   idx_q, matched_q;
  logic [CopyW-1:0]  copied_q, maxc_q;
  logic [CntW-1:0]   skip_q;
  logic              pend_q, latest_mode_q;
  logic [StampW-1:0] latest_q, from_q, to_q;
  logic [PidW-1:0]   pid_q;
  logic [TidW-1:0]   tid_q;

  // memory
  rec_t              mem_q [RING_DEPTH];
  rec_t              rdata_q;
  logic              mem_we;

  // output registers
  logic              out_valid_q, is_record_q, last_q;
  logic [StampW-1:0] out_ts_q;
  logic [PidW-1:0]   out_pid_q;
  logic [TidW-1:0]   out_tid_q;
  logic [WordW-1:0]  out_pl_q, out_wr_q, out_dr_q;
  logic [CntW-1:0]   out_matched_q, out_used_q;
  logic [CopyW-1:0]  out_copied_q;

  logic              accept, issue, hit, emit, sum_go, rec_go;
  logic [CntW-1:0]   used_sat, matched_sat;

  assign accept = start_i && (state_q == ST_IDLE) && !cfg_we_i;
  assign busy_o = (state_q != ST_IDLE);

  // capacity clamp for a configuration write
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_d = CapW'(1);
    end else if (32'(cfg_wdata_i) > 32'(RING_DEPTH)) begin
      cap_d = CapW'(RING_DEPTH);
    end else begin
      cap_d = CapW'(cfg_wdata_i);
    end
  end

  // ring pointer arithmetic
  always_comb begin
    tail_sum = (CapW + 1)'(wp_q) + (CapW + 1)'(cap_q) - (CapW + 1)'(fill_q);
    if (tail_sum >= (CapW + 1)'(cap_q)) begin
      tail = PtrW'(tail_sum - (CapW + 1)'(cap_q));
    end else begin
      tail = PtrW'(tail_sum);
    end
    newest     = (wp_q == '0) ? PtrW'(cap_q - CapW'(1)) : wp_q - PtrW'(1);
    wp_nxt     = ((CapW'(wp_q) + CapW'(1)) == cap_q) ? '0 : wp_q + PtrW'(1);
    rd_ptr_nxt = ((CapW'(rd_ptr_q) + CapW'(1)) == cap_q) ? '0 : rd_ptr_q + PtrW'(1);
    rd_addr    = (state_q == ST_NEWEST) ? newest : rd_ptr_q;
  end

  // shared compare unit: filter test of the record read last cycle
  always_comb begin
    if (latest_mode_q) begin
      hit = (rdata_q.ts == latest_q);
    end else begin
      hit = ((from_q == '0) || (rdata_q.ts >= from_q)) &&
            ((to_q == '0) || (rdata_q.ts <= to_q)) &&
            ((pid_q == '0) || (rdata_q.pid == pid_q)) &&
            ((tid_q == '0) || (rdata_q.tid == tid_q));
    end
    emit   = (32'(matched_q) >= 32'(skip_q)) && (copied_q < maxc_q);
    issue  = (idx_q != fill_q);
    rec_go = (state_q == ST_SCAN) && pend_q && hit && emit;
    sum_go = (state_q == ST_FIN) || ((state_q == ST_SCAN) && !issue && !pend_q);
  end

  // saturated counts for the summary beat
  assign used_sat    = (32'(fill_q) > 32'(SatMax)) ? CntW'(SatMax) : CntW'(fill_q);
  assign matched_sat = (32'(matched_q) > 32'(SatMax)) ? CntW'(SatMax) : CntW'(matched_q);

  // record memory, one write and one registered read port
  assign mem_we = accept && (req_type_i == REQ_WRITE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= '{ts: rec_timestamp_i, pid: rec_pid_i, tid: rec_tid_i,
                       pl: PAYLOAD_BITS'(rec_payload_i)};
    end
    rdata_q <= mem_q[rd_addr];
  end

  // sequencer, ring state and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cap_q         <= CapW'(RING_DEPTH);
      wp_q          <= '0;
      fill_q        <= '0;
      written_q     <= '0;
      dropped_q     <= '0;
      rd_ptr_q      <= '0;
      idx_q         <= '0;
      matched_q     <= '0;
      copied_q      <= '0;
      maxc_q        <= '0;
      skip_q        <= '0;
      pend_q        <= 1'b0;
      latest_mode_q <= 1'b0;
      latest_q      <= '0;
      from_q        <= '0;
      to_q          <= '0;
      pid_q         <= '0;
      tid_q         <= '0;
      out_valid_q   <= 1'b0;
      is_record_q   <= 1'b0;
      last_q        <= 1'b0;
      out_ts_q      <= '0;
      out_pid_q     <= '0;
      out_tid_q     <= '0;
      out_pl_q      <= '0;
      out_matched_q <= '0;
      out_copied_q  <= '0;
      out_used_q    <= '0;
      out_wr_q      <= '0;
      out_dr_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cfg_we_i) begin
            cap_q  <= cap_d;
            wp_q   <= '0;
            fill_q <= '0;
          end else if (start_i) begin
            from_q        <= from_time_i;
            to_q          <= to_time_i;
            pid_q         <= pid_filter_i;
            tid_q         <= unsigned'(tid_filter_i);
            maxc_q        <= max_copies_i;
            // latest mode emits from the first match on
            skip_q        <= (req_type_i == REQ_LATEST) ? '0 : skip_count_i;
            matched_q     <= '0;
            copied_q      <= '0;
            idx_q         <= '0;
            pend_q        <= 1'b0;
            rd_ptr_q      <= tail;
            latest_mode_q <= (req_type_i == REQ_LATEST);
            case (req_type_i)
              REQ_WRITE: begin
                if (fill_q >= cap_q) begin
                  dropped_q <= dropped_q + WordW'(1);
                end else begin
                  fill_q <= fill_q + CapW'(1);
                end
                written_q <= written_q + WordW'(1);
                wp_q      <= wp_nxt;
                state_q   <= ST_FIN;
              end
              REQ_QUERY: begin
                state_q <= (fill_q == '0) ? ST_FIN : ST_SCAN;
              end
              REQ_LATEST: begin
                state_q <= (fill_q == '0) ? ST_FIN : ST_NEWEST;
              end
              default: begin
                state_q <= ST_FIN;
              end
            endcase
          end
        end
        ST_NEWEST: begin
          state_q <= ST_GRAB;
        end
        ST_GRAB: begin
          latest_q <= rdata_q.ts;
          state_q  <= ST_SCAN;
        end
        ST_SCAN: begin
          // issue the next slot while testing the one read last cycle
          if (issue) begin
            idx_q    <= idx_q + CapW'(1);
            rd_ptr_q <= rd_ptr_nxt;
          end
          pend_q <= issue;
          if (pend_q && hit) begin
            matched_q <= matched_q + CapW'(1);
          end
          if (rec_go) begin
            copied_q <= copied_q + CopyW'(1);
          end
          if (sum_go) begin
            state_q <= ST_IDLE;
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // result beat
      out_valid_q <= rec_go || sum_go;
      if (rec_go) begin
        is_record_q   <= 1'b1;
        last_q        <= 1'b0;
        out_ts_q      <= rdata_q.ts;
        out_pid_q     <= rdata_q.pid;
        out_tid_q     <= rdata_q.tid;
        out_pl_q      <= WordW'(rdata_q.pl);
        out_matched_q <= '0;
        out_copied_q  <= '0;
        out_used_q    <= '0;
        out_wr_q      <= '0;
        out_dr_q      <= '0;
      end else if (sum_go) begin
        is_record_q   <= 1'b0;
        last_q        <= 1'b1;
        out_ts_q      <= '0;
        out_pid_q     <= '0;
        out_tid_q     <= '0;
        out_pl_q      <= '0;
        out_matched_q <= matched_sat;
        out_copied_q  <= copied_q;
        out_used_q    <= used_sat;
        out_wr_q      <= written_q;
        out_dr_q      <= dropped_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_record_o     = is_record_q;
  assign last_item_o     = last_q;
  assign out_timestamp_o = out_ts_q;
  assign out_pid_o       = out_pid_q;
  assign out_tid_o       = signed'(out_tid_q);
  assign out_payload_o   = out_pl_q;
  assign matched_total_o = out_matched_q;
  assign copied_total_o  = out_copied_q;
  assign used_count_o    = out_used_q;
  assign written_total_o = out_wr_q;
  assign dropped_total_o = out_dr_q;

  // checks
  `ORWFQ_ASSERT_IMP(a_fill_in_cap, 1'b1, fill_q <= cap_q, "fill exceeds capacity")
  `ORWFQ_ASSERT_IMP(a_wp_in_cap, 1'b1, CapW'(wp_q) < cap_q, "head pointer past capacity")
  `ORWFQ_ASSERT_IMP(a_copy_limit, state_q == ST_SCAN, copied_q <= maxc_q,
                    "more records emitted than allowed")
  `ORWFQ_ASSERT_NXT(a_accept_busy, accept, busy_o, "accepted request left block idle")
  `ORWFQ_ASSERT_IMP(a_last_is_summary, out_valid_q && last_q, !is_record_q,
                    "final beat carries a record")

endmodule
